// ----- rtl/core/icmper_pkg.sv -----
// Shared types, codes and helpers for the ICMP echo reply checker.
// Depends on nothing; icmper_out_if, icmper_cfg_if, icmper_parse and the top level use it.
`timescale 1ns / 1ps

package icmper_pkg;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_TARGET_ADDRESS  = 2'd0;
  localparam cfg_idx_t REG_ECHO_IDENTIFIER = 2'd1;
  localparam cfg_idx_t REG_FIRST_SEQUENCE  = 2'd2;

  localparam int CFG_DATA_W = 32;

  // Verdict codes, first failing check wins.
  typedef logic [2:0] verdict_t;
  localparam verdict_t VERDICT_OK        = 3'd0;
  localparam verdict_t VERDICT_MALFORMED = 3'd1;
  localparam verdict_t VERDICT_IP_CSUM   = 3'd2;
  localparam verdict_t VERDICT_ICMP_CSUM = 3'd3;
  localparam verdict_t VERDICT_SOURCE    = 3'd4;
  localparam verdict_t VERDICT_ID        = 3'd5;

  // Fixed header geometry.
  localparam logic [5:0] MIN_HEADER_LEN = 6'd20;
  localparam logic [3:0] ICMP_HDR_LEN   = 4'd8;

  // What the parser knows about a packet once its last byte is in.
  typedef struct packed {
    logic        malformed;
    logic        ip_sum_ok;
    logic        icmp_sum_ok;
    logic        type_code_zero;
    logic [31:0] source;
    logic [15:0] echo_id;
    logic [15:0] sequence_num;
  } summary_t;

  // Ones-complement add with end-around carry.
  function automatic logic [15:0] oc_add(input logic [15:0] s, input logic [15:0] w);
    logic [16:0] t;
    t = {1'b0, s} + {1'b0, w};
    return t[15:0] + {15'd0, t[16]};
  endfunction

endpackage

// ----- rtl/core/icmper_in_if.sv -----
// Byte request channel into the ICMP echo reply checker.
// Depends on nothing but the handshake convention valid/ready.
`timescale 1ns / 1ps

interface icmper_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, data_byte, last_byte, input ready);
  modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

// ----- rtl/core/icmper_out_if.sv -----
// Result request channel out of the ICMP echo reply checker.
// Depends on icmper_pkg for the verdict type.
`timescale 1ns / 1ps

interface icmper_out_if;
  logic                 valid;
  logic                 ready;
  icmper_pkg::verdict_t verdict;
  logic                 type_code_ok;
  logic                 sequence_match;
  logic [15:0]          success_count;

  modport source (output valid, verdict, type_code_ok, sequence_match, success_count,
                  input ready);
  modport sink   (input valid, verdict, type_code_ok, sequence_match, success_count,
                  output ready);
endinterface

// ----- rtl/core/icmper_cfg_if.sv -----
// Configuration write channel of the ICMP echo reply checker.
// Depends on icmper_pkg for index and data widths.
`timescale 1ns / 1ps

interface icmper_cfg_if;
  logic                                   valid;
  logic                                   ready;
  icmper_pkg::cfg_idx_t                   index;
  logic [icmper_pkg::CFG_DATA_W-1:0]      data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/core/icmper_parse.sv -----
// Per-packet byte parser: header fields, both running checksums, captured ICMP fields.
// Depends on icmper_pkg for oc_add and summary_t.
`timescale 1ns / 1ps

module icmper_parse #(
  parameter int MAX_PACKET_BYTES = 1024
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  logic [7:0]           data_byte,
  input  logic                 last_byte,
  output icmper_pkg::summary_t summary
);
  import icmper_pkg::*;

  localparam int PW = $clog2(MAX_PACKET_BYTES + 1);
  localparam int XW = 17;
  localparam logic [XW-1:0] MAX_X = XW'(MAX_PACKET_BYTES);

  logic [PW-1:0] pos_r, pos_nxt;
  logic [5:0]    hl_r, hl_nxt;
  logic [15:0]   tot_r, tot_nxt;
  logic [15:0]   ip_sum_r, ip_sum_nxt;
  logic [15:0]   icmp_sum_r, icmp_sum_nxt;
  logic [7:0]    held_r, held_nxt;
  logic [15:0]   ip_chk_r, ip_chk_nxt;
  logic [15:0]   icmp_chk_r, icmp_chk_nxt;
  logic [31:0]   src_r, src_nxt;
  logic [15:0]   id_r, id_nxt;
  logic [15:0]   seq_r, seq_nxt;
  logic [15:0]   tc_r, tc_nxt;

  logic [XW-1:0] p_x, rel_x;
  logic          payload;
  logic [15:0]   word;

  always_comb begin
    pos_nxt      = pos_r;
    hl_nxt       = hl_r;
    tot_nxt      = tot_r;
    ip_sum_nxt   = ip_sum_r;
    icmp_sum_nxt = icmp_sum_r;
    held_nxt     = held_r;
    ip_chk_nxt   = ip_chk_r;
    icmp_chk_nxt = icmp_chk_r;
    src_nxt      = src_r;
    id_nxt       = id_r;
    seq_nxt      = seq_r;
    tc_nxt       = tc_r;
    p_x          = XW'(pos_r);
    payload      = 1'b0;
    rel_x        = '0;
    word         = {held_r, data_byte};

    if (pos_r < PW'(MAX_PACKET_BYTES)) begin
      pos_nxt = pos_r + PW'(1);

      // Header fields take effect for this same byte's decisions.
      if (pos_r == PW'(0)) hl_nxt = {data_byte[3:0], 2'b00};
      if (pos_r == PW'(2)) tot_nxt = {data_byte, tot_r[7:0]};
      if (pos_r == PW'(3)) tot_nxt = {tot_r[15:8], data_byte};
      if (pos_r == PW'(10)) ip_chk_nxt = {data_byte, ip_chk_r[7:0]};
      if (pos_r == PW'(11)) ip_chk_nxt = {ip_chk_r[15:8], data_byte};
      if (pos_r == PW'(12)) src_nxt[31:24] = data_byte;
      if (pos_r == PW'(13)) src_nxt[23:16] = data_byte;
      if (pos_r == PW'(14)) src_nxt[15:8]  = data_byte;
      if (pos_r == PW'(15)) src_nxt[7:0]   = data_byte;

      payload = p_x >= XW'(hl_nxt);
      rel_x   = p_x - XW'(hl_nxt);
      if (payload && rel_x < XW'(ICMP_HDR_LEN)) begin
        case (rel_x[2:0])
          3'd0:    tc_nxt       = {data_byte, tc_r[7:0]};
          3'd1:    tc_nxt       = {tc_r[15:8], data_byte};
          3'd2:    icmp_chk_nxt = {data_byte, icmp_chk_r[7:0]};
          3'd3:    icmp_chk_nxt = {icmp_chk_r[15:8], data_byte};
          3'd4:    id_nxt       = {data_byte, id_r[7:0]};
          3'd5:    id_nxt       = {id_r[15:8], data_byte};
          3'd6:    seq_nxt      = {data_byte, seq_r[7:0]};
          default: seq_nxt      = {seq_r[15:8], data_byte};
        endcase
      end

      if (!pos_r[0]) begin
        held_nxt = data_byte;
        // A lone trailing byte counts as the high half of a padded word.
        if (payload && (p_x + XW'(1)) == XW'(tot_nxt))
          icmp_sum_nxt = oc_add(icmp_sum_r, {data_byte, 8'h00});
      end else if (!payload) begin
        if (pos_r != PW'(11)) ip_sum_nxt = oc_add(ip_sum_r, word);
      end else if (p_x < XW'(tot_nxt)) begin
        if (rel_x != XW'(3)) icmp_sum_nxt = oc_add(icmp_sum_r, word);
      end
    end
  end

  always_comb begin
    summary.malformed      = (hl_nxt < MIN_HEADER_LEN)
                           || (XW'(tot_nxt) < XW'(hl_nxt) + XW'(ICMP_HDR_LEN))
                           || (XW'(tot_nxt) > MAX_X)
                           || (XW'(pos_nxt) < XW'(tot_nxt));
    summary.ip_sum_ok      = ip_chk_nxt == ~ip_sum_nxt;
    summary.icmp_sum_ok    = icmp_chk_nxt == ~icmp_sum_nxt;
    summary.type_code_zero = tc_nxt == 16'd0;
    summary.source         = src_nxt;
    summary.echo_id        = id_nxt;
    summary.sequence_num   = seq_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step && last_byte)) begin
      pos_r      <= '0;
      hl_r       <= '0;
      tot_r      <= '0;
      ip_sum_r   <= '0;
      icmp_sum_r <= '0;
      held_r     <= '0;
      ip_chk_r   <= '0;
      icmp_chk_r <= '0;
      src_r      <= '0;
      id_r       <= '0;
      seq_r      <= '0;
      tc_r       <= '0;
    end else if (step) begin
      pos_r      <= pos_nxt;
      hl_r       <= hl_nxt;
      tot_r      <= tot_nxt;
      ip_sum_r   <= ip_sum_nxt;
      icmp_sum_r <= icmp_sum_nxt;
      held_r     <= held_nxt;
      ip_chk_r   <= ip_chk_nxt;
      icmp_chk_r <= icmp_chk_nxt;
      src_r      <= src_nxt;
      id_r       <= id_nxt;
      seq_r      <= seq_nxt;
      tc_r       <= tc_nxt;
    end
  end

endmodule

// ----- rtl/core/icmp_echo_reply_checker.sv -----
// Top level of the ICMP echo reply checker: input register, parser, verdict and result register.
// Depends on icmper_pkg, the three channel interfaces and icmper_parse.
//
// Usage:
//   in_bus carries a received IPv4 packet one byte per request, in wire order, with
//   last_byte set on its final byte. One byte is taken per clock, back to back, while
//   no last byte waits behind an unaccepted result. out_bus gives one result per
//   packet: verdict, type_code_ok, sequence_match and the saturating count of good
//   packets. cfg_bus writes target_address (index 0), echo_identifier (index 1) and
//   first_sequence (index 2); it is always ready. The user must write it only while no
//   packet is in flight; the block does not enforce this. Writing first_sequence also
//   reloads the expected sequence number.
//   The last byte sits in the input register; the parser and verdict logic then load
//   the result register from it.
//   Throughput: one byte per cycle while no last byte is held back; the running checksums
//   take one ones-complement add per byte, so the next byte follows at once.
//   When the receiver stalls, the pending result waits in the result register while
//   further bytes keep flowing; only a second last byte waits in the input register
//   until the result is taken, and in_bus.ready drops meanwhile.
//   Reset (rst_n low, synchronous) clears all packet state, the count and the
//   configuration registers, and loads an expected sequence of 1.
`timescale 1ns / 1ps

module icmp_echo_reply_checker #(
  parameter int MAX_PACKET_BYTES = 1024
) (
  input  logic         clk,
  input  logic         rst_n,
  icmper_in_if.sink    in_bus,
  icmper_out_if.source out_bus,
  icmper_cfg_if.sink   cfg_bus
);
  import icmper_pkg::*;

  logic        s1_valid_r;
  logic [7:0]  s1_byte_r;
  logic        s1_last_r;
  logic        adv;
  logic        in_fire;
  logic        cfg_fire;
  logic        finish;

  logic [31:0] target_r;
  logic [15:0] echo_id_r;
  logic [15:0] exp_seq_r;
  logic [15:0] good_r, good_nxt;

  summary_t    summary;
  verdict_t    verdict_nxt;

  logic        out_valid_r;
  verdict_t    verdict_r;
  logic        tc_ok_r;
  logic        seq_match_r;

  // The parser steps whenever the input register holds a byte, unless that byte
  // ends a packet and the result register is still occupied.
  assign adv      = s1_valid_r && (!s1_last_r || !out_valid_r || out_bus.ready);
  assign finish   = adv && s1_last_r;
  assign in_fire  = in_bus.valid && in_bus.ready;
  assign cfg_fire = cfg_bus.valid && cfg_bus.ready;

  assign in_bus.ready  = !s1_valid_r || adv;
  assign cfg_bus.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r <= in_bus.data_byte;
      s1_last_r <= in_bus.last_byte;
    end
  end

  icmper_parse #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
  ) u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (adv),
    .data_byte (s1_byte_r),
    .last_byte (s1_last_r),
    .summary   (summary)
  );

  always_comb begin
    if (summary.malformed) begin
      verdict_nxt = VERDICT_MALFORMED;
    end else if (!summary.ip_sum_ok) begin
      verdict_nxt = VERDICT_IP_CSUM;
    end else if (!summary.icmp_sum_ok) begin
      verdict_nxt = VERDICT_ICMP_CSUM;
    end else if (summary.source != target_r) begin
      verdict_nxt = VERDICT_SOURCE;
    end else if (summary.echo_id != echo_id_r) begin
      verdict_nxt = VERDICT_ID;
    end else begin
      verdict_nxt = VERDICT_OK;
    end
    good_nxt = good_r;
    if (verdict_nxt == VERDICT_OK && good_r != 16'hffff) good_nxt = good_r + 16'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r  <= '0;
      echo_id_r <= '0;
      exp_seq_r <= 16'd1;
      good_r    <= '0;
    end else begin
      if (cfg_fire) begin
        unique case (cfg_bus.index)
          REG_TARGET_ADDRESS:  target_r  <= cfg_bus.data;
          REG_ECHO_IDENTIFIER: echo_id_r <= cfg_bus.data[15:0];
          REG_FIRST_SEQUENCE:  exp_seq_r <= cfg_bus.data[15:0];
          default: ;
        endcase
      end
      if (finish) begin
        exp_seq_r <= exp_seq_r + 16'd1;
        good_r    <= good_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (finish) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      verdict_r   <= verdict_nxt;
      tc_ok_r     <= summary.type_code_zero;
      seq_match_r <= summary.sequence_num == exp_seq_r;
    end
  end

  assign out_bus.valid          = out_valid_r;
  assign out_bus.verdict        = verdict_r;
  assign out_bus.type_code_ok   = tc_ok_r;
  assign out_bus.sequence_match = seq_match_r;
  assign out_bus.success_count  = good_r;

  // Input stalls only when a last byte is blocked behind an unaccepted result.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_bus.ready |-> (s1_valid_r && s1_last_r && out_valid_r && !out_bus.ready))
    else $error("input stalled without a blocked last byte");

  // A good packet bumps the count unless it is already saturated.
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (finish && verdict_nxt == VERDICT_OK && good_r != 16'hffff)
      |=> good_r == $past(good_r) + 16'd1)
    else $error("success count did not advance on a good packet");

  // The count never moves without a finished packet.
  a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !finish |=> $stable(good_r))
    else $error("success count changed between packets");

  // Every finished packet advances the expected sequence by one.
  a_seq_step: assert property (@(posedge clk) disable iff (!rst_n)
    (finish && !cfg_fire) |=> exp_seq_r == $past(exp_seq_r) + 16'd1)
    else $error("expected sequence did not advance");

endmodule
